// ===== src/bpa_pkg.sv =====
// Package for the bitmap page allocator: sizes, field widths, action and
// status codes, and bit helpers for one bitmap word.
// No dependencies.
`default_nettype none

package bpa_pkg;

   localparam int NUM_PAGES = 65536;
   localparam int WORD_BITS = 32;
   localparam int NUM_WORDS = NUM_PAGES / WORD_BITS;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int WADDR_W   = $clog2(NUM_WORDS);
   localparam int SCAN_W    = WADDR_W + 1;
   localparam int CNT_W     = $clog2(WORD_BITS + 1);

   localparam int ACTION_W  = 2;
   localparam int PAGE_W    = 16;
   localparam int COUNT_W   = 17;
   localparam int LIMIT_W   = 17;
   localparam int STATUS_W  = 2;
   localparam int FREE_W    = 17;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(NUM_PAGES);

   typedef logic [WORD_BITS-1:0] word_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ALLOC   = 2'd0,
      ACT_FREE    = 2'd1,
      ACT_RESERVE = 2'd2,
      ACT_RELEASE = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_NO_FREE = 2'd1,
      ST_RANGE   = 2'd2,
      ST_DOUBLE  = 2'd3
   } status_type;

   function automatic logic [BIT_W-1:0] lowest_set(input word_type v);
      logic [BIT_W-1:0] r;
      r = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (v[b]) begin
            r = BIT_W'(b);
         end
      end
      return r;
   endfunction

   function automatic logic [CNT_W-1:0] ones(input word_type v);
      logic [CNT_W-1:0] n;
      n = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         n = n + CNT_W'(v[b]);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== src/bitmap_page_allocator.sv =====
// Bitmap page allocator top level: bitmap RAM, scan and region sequencer.
// Depends on bpa_pkg.
`default_nettype none

// Usage
//   Input: drive req_action, req_page, req_count and raise start; the word is
//   taken at a clock edge where start is high and busy is low.
//   Output: rsp_valid is high for exactly one cycle with rsp_page_out,
//   rsp_status and rsp_free_pages; the receiver must take it then.
//   csr_we with csr_wdata writes page_limit; write only while idle.
// Sequencing
//   Rejected words (out of range, hint at or above limit) are answered from idle.
//   Free reads the one bitmap word that holds the page. Allocate scans bitmap words from the hint.
//   Reserve / release visit every bitmap word the run touches.
//   Each bitmap word is read in S_READ and modified and written back in S_EVAL
//   through the single-ported-per-direction bitmap RAM.
//   A new word can be taken in the cycle rsp_valid is high.
// Reset
//   Synchronous reset starts a fill pass that writes every bitmap word to
//   all used, with busy high. Hint and free count clear, page_limit
//   returns to 65536.

module bitmap_page_allocator (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   output logic                          busy,
   input  wire  [bpa_pkg::ACTION_W-1:0]  req_action,
   input  wire  [bpa_pkg::PAGE_W-1:0]    req_page,
   input  wire  [bpa_pkg::COUNT_W-1:0]   req_count,
   output logic                          rsp_valid,
   output logic [bpa_pkg::PAGE_W-1:0]    rsp_page_out,
   output logic [bpa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [bpa_pkg::FREE_W-1:0]    rsp_free_pages,
   input  wire                           csr_we,
   input  wire  [bpa_pkg::LIMIT_W-1:0]   csr_wdata
);
   import bpa_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_READ  = 4'b0100,
      S_EVAL  = 4'b1000
   } state_type;

   localparam word_type FULL = '1;

   word_type mem [NUM_WORDS];
   word_type mem_rd_ff;

   state_type            state_ff, state_in;
   action_type           op_ff, op_in;
   logic [SCAN_W-1:0]    addr_ff, addr_in;
   logic [SCAN_W-1:0]    end_w_ff, end_w_in;
   logic                 first_ff, first_in;
   logic [BIT_W-1:0]     lo_b_ff, lo_b_in;
   logic [BIT_W-1:0]     hi_b_ff, hi_b_in;
   logic [PAGE_W-1:0]    page_ff, page_in;
   logic [PAGE_W-1:0]    hint_ff, hint_in;
   logic [FREE_W-1:0]    free_ff, free_in;
   logic [LIMIT_W-1:0]   limit_ff;
   logic [WADDR_W-1:0]   clr_ff, clr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [PAGE_W-1:0]    rsp_page_ff, rsp_page_in;
   status_type           rsp_status_ff, rsp_status_in;

   logic                 mem_we;
   logic [WADDR_W-1:0]   mem_waddr;
   word_type             mem_wdata;

   logic [LIMIT_W-1:0]   eff;
   logic [SCAN_W-1:0]    lim_floor;
   logic [SCAN_W-1:0]    lim_ceil;
   logic [COUNT_W:0]     reg_end;
   logic [COUNT_W:0]     reg_last;
   word_type             smask, lmask, rmask, cand, flip;
   logic [BIT_W-1:0]     found_b;
   logic [PAGE_W-1:0]    found_p;
   logic [SCAN_W-1:0]    addr_nx;
   logic                 last_w;

   assign eff       = limit_ff[LIMIT_W-1] ? LIMIT_W'(NUM_PAGES) : limit_ff;
   assign lim_floor = SCAN_W'(eff >> BIT_W);
   assign lim_ceil  = lim_floor + SCAN_W'(eff[BIT_W-1:0] != '0);
   assign reg_end   = (COUNT_W+1)'(req_page) + (COUNT_W+1)'(req_count);
   assign reg_last  = reg_end - (COUNT_W+1)'(1);

   assign smask   = first_ff ? (FULL << lo_b_ff) : FULL;
   assign lmask   = (addr_ff == lim_floor) ? ((word_type'(1) << eff[BIT_W-1:0]) - word_type'(1))
                                           : FULL;
   assign last_w  = (addr_ff == end_w_ff);
   assign rmask   = smask & (last_w ? (FULL >> (BIT_W'(WORD_BITS - 1) - hi_b_ff)) : FULL);
   assign cand    = ~mem_rd_ff & smask & lmask;
   assign found_b = lowest_set(cand);
   assign found_p = PAGE_W'({addr_ff[WADDR_W-1:0], found_b});
   assign addr_nx = addr_ff + SCAN_W'(1);
   assign flip    = (op_ff == ACT_RESERVE) ? (~mem_rd_ff & rmask) : (mem_rd_ff & rmask);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      end_w_in      = end_w_ff;
      first_in      = first_ff;
      lo_b_in       = lo_b_ff;
      hi_b_in       = hi_b_ff;
      page_in       = page_ff;
      hint_in       = hint_ff;
      free_in       = free_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = 1'b0;
      rsp_page_in   = '0;
      rsp_status_in = ST_OK;
      mem_we        = 1'b0;
      mem_waddr     = addr_ff[WADDR_W-1:0];
      mem_wdata     = mem_rd_ff;

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = FULL;
            clr_in    = clr_ff + WADDR_W'(1);
            if (clr_ff == WADDR_W'(NUM_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               op_in   = action_type'(req_action);
               page_in = req_page;
               case (action_type'(req_action))
                  ACT_ALLOC: begin
                     if (LIMIT_W'(hint_ff) >= eff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NO_FREE;
                     end else begin
                        addr_in  = SCAN_W'(hint_ff >> BIT_W);
                        first_in = 1'b1;
                        lo_b_in  = hint_ff[BIT_W-1:0];
                        end_w_in = lim_ceil;
                        state_in = S_READ;
                     end
                  end
                  ACT_FREE: begin
                     if (LIMIT_W'(req_page) >= eff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_RANGE;
                     end else begin
                        addr_in  = SCAN_W'(req_page >> BIT_W);
                        state_in = S_READ;
                     end
                  end
                  ACT_RESERVE, ACT_RELEASE: begin
                     if (req_count == '0 || reg_end > (COUNT_W+1)'(eff)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_RANGE;
                     end else begin
                        addr_in  = SCAN_W'(req_page >> BIT_W);
                        first_in = 1'b1;
                        lo_b_in  = req_page[BIT_W-1:0];
                        end_w_in = SCAN_W'(reg_last[PAGE_W-1:0] >> BIT_W);
                        hi_b_in  = reg_last[BIT_W-1:0];
                        state_in = S_READ;
                        if (action_type'(req_action) == ACT_RELEASE && req_page < hint_ff) begin
                           hint_in = req_page;
                        end
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            case (op_ff)
               ACT_ALLOC: begin
                  if (cand != '0) begin
                     mem_we        = 1'b1;
                     mem_wdata     = mem_rd_ff | (word_type'(1) << found_b);
                     free_in       = free_ff - FREE_W'(1);
                     hint_in       = found_p + PAGE_W'(1);
                     rsp_valid_in  = 1'b1;
                     rsp_page_in   = found_p;
                     state_in      = S_IDLE;
                  end else if (addr_nx < end_w_ff) begin
                     addr_in  = addr_nx;
                     first_in = 1'b0;
                     state_in = S_READ;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_NO_FREE;
                     state_in      = S_IDLE;
                  end
               end
               ACT_FREE: begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
                  if (!mem_rd_ff[page_ff[BIT_W-1:0]]) begin
                     rsp_status_in = ST_DOUBLE;
                  end else begin
                     mem_we    = 1'b1;
                     mem_wdata = mem_rd_ff & ~(word_type'(1) << page_ff[BIT_W-1:0]);
                     free_in   = free_ff + FREE_W'(1);
                     if (page_ff < hint_ff) begin
                        hint_in = page_ff;
                     end
                  end
               end
               ACT_RESERVE, ACT_RELEASE: begin
                  mem_we = 1'b1;
                  if (op_ff == ACT_RESERVE) begin
                     mem_wdata = mem_rd_ff | rmask;
                     free_in   = free_ff - FREE_W'(ones(flip));
                  end else begin
                     mem_wdata = mem_rd_ff & ~rmask;
                     free_in   = free_ff + FREE_W'(ones(flip));
                  end
                  if (last_w) begin
                     rsp_valid_in = 1'b1;
                     state_in     = S_IDLE;
                  end else begin
                     addr_in  = addr_nx;
                     first_in = 1'b0;
                     state_in = S_READ;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (state_ff == S_READ) begin
         mem_rd_ff <= mem[addr_ff[WADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         hint_ff      <= '0;
         free_ff      <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         hint_ff      <= hint_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      end_w_ff      <= end_w_in;
      first_ff      <= first_in;
      lo_b_ff       <= lo_b_in;
      hi_b_ff       <= hi_b_in;
      page_ff       <= page_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_page_out   = rsp_page_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_free_pages = free_ff;

endmodule

`default_nettype wire

// ===== src/bpa_checker.sv =====
// Port-level checks for the bitmap page allocator, bound to the top level.
// Depends on bpa_pkg and bitmap_page_allocator.
`default_nettype none

module bpa_checker (
   input wire                           clock,
   input wire                           reset,
   input wire                           start,
   input wire                           busy,
   input wire                           rsp_valid,
   input wire [bpa_pkg::PAGE_W-1:0]     rsp_page_out,
   input wire [bpa_pkg::STATUS_W-1:0]   rsp_status
);
   import bpa_pkg::*;

   a_reset_fill: assert property (@(posedge clock) reset |=> busy)
      else $error("bitmap fill pass not started after reset");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted word neither answered nor in progress");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while busy");

   a_fail_page_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_page_out == '0))
      else $error("failed response carries a nonzero page");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_page_out (rsp_page_out),
   .rsp_status   (rsp_status)
);

`default_nettype wire
